### design/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the min-heap priority queue: data and
// occupancy widths, the request type and the command broadcast to every cell.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_type_t;

    // command seen by all cells in the cycle a request is carried out
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

### design/mhpq_cell.sv
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted register chain. Holds one entry and its valid bit.
// On insert it keeps its entry, takes the new value, or takes its left
// neighbor's entry; on remove it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module mhpq_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mhpq_pkg::cell_cmd_t               cmd,
    input  logic                              left_gt,
    input  logic signed [mhpq_pkg::DATA_W-1:0] left_val,
    input  logic                              left_vld,
    input  logic signed [mhpq_pkg::DATA_W-1:0] right_val,
    input  logic                              right_vld,
    output logic signed [mhpq_pkg::DATA_W-1:0] val,
    output logic                              vld,
    output logic                              gt
);

    logic signed [mhpq_pkg::DATA_W-1:0] val_reg, val_next;
    logic                               vld_reg, vld_next;

    // new value belongs at or before this slot
    assign gt = !vld_reg || (cmd.value < val_reg);

    always_comb begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (cmd.ins && gt) begin
            if (left_gt) begin
                val_next = left_val;
                vld_next = left_vld;
            end else begin
                val_next = cmd.value;
                vld_next = 1'b1;
            end
        end else if (cmd.rem) begin
            val_next = right_val;
            vld_next = right_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;

endmodule

### design/min_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Priority queue of signed 32-bit values kept as a sorted chain of cells,
// smallest entry in cell 0. Each request inserts or removes the minimum and
// returns acceptance, the new minimum, the count and an empty flag.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+---------------------------------------
//   s_      | in  | s_valid/s_ready  | s_req_type, s_value
//   m_      | out | m_valid/m_ready  | m_accepted, m_front_value,
//           |     |                  | m_occupancy, m_is_empty
//
// One request per cycle: every cell updates in the cycle of the transfer,
// the result appears in the output register on the next cycle.
// s_ready is low while a result waits in the output register and m_ready is
// low; the chain holds its state through such stalls.
// Synchronous active-low reset empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic signed [mhpq_pkg::DATA_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_accepted,
    output logic signed [mhpq_pkg::DATA_W-1:0] m_front_value,
    output logic [mhpq_pkg::OCC_W-1:0]         m_occupancy,
    output logic                               m_is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DW    = mhpq_pkg::DATA_W;
    localparam int OW    = mhpq_pkg::OCC_W;

    logic signed [DW-1:0] cell_val [CAPACITY];
    logic                 cell_vld [CAPACITY];
    logic                 cell_gt  [CAPACITY];
    logic signed [DW-1:0] second_val;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg;
    logic                 accepted_reg, accepted_next;
    logic signed [DW-1:0] front_reg, front_next;
    logic [OW-1:0]        occ_reg;
    logic                 empty_reg;

    logic                 s_xfer, full, ins_ok, rem_ok;
    mhpq_pkg::cell_cmd_t  cmd;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign ins_ok  = s_xfer && (s_req_type == mhpq_pkg::REQ_INSERT) && !full;
    assign rem_ok  = s_xfer && (s_req_type == mhpq_pkg::REQ_REMOVE) &&
                     (count_reg != '0);

    assign cmd = '{ins: ins_ok, rem: rem_ok, value: s_value};

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic                 l_gt, l_vld, r_vld;
            logic signed [DW-1:0] l_val, r_val;
            if (i == 0) begin : g_first
                assign l_gt  = 1'b0;
                assign l_val = '0;
                assign l_vld = 1'b0;
            end else begin : g_mid_l
                assign l_gt  = cell_gt[i-1];
                assign l_val = cell_val[i-1];
                assign l_vld = cell_vld[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign r_val = '0;
                assign r_vld = 1'b0;
            end else begin : g_mid_r
                assign r_val = cell_val[i+1];
                assign r_vld = cell_vld[i+1];
            end
            mhpq_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .left_gt   (l_gt),
                .left_val  (l_val),
                .left_vld  (l_vld),
                .right_val (r_val),
                .right_vld (r_vld),
                .val       (cell_val[i]),
                .vld       (cell_vld[i]),
                .gt        (cell_gt[i])
            );
        end
        if (CAPACITY > 1) begin : g_second
            assign second_val = cell_val[1];
        end else begin : g_no_second
            assign second_val = '0;
        end
    endgenerate

    // result of the request, from the chain as it stands before the update
    always_comb begin
        count_next    = count_reg;
        accepted_next = 1'b0;
        front_next    = (count_reg != '0) ? cell_val[0] : '0;
        if (ins_ok) begin
            count_next    = count_reg + CNT_W'(1);
            accepted_next = 1'b1;
            if ((count_reg == '0) || (s_value < cell_val[0])) begin
                front_next = s_value;
            end
        end else if (rem_ok) begin
            count_next    = count_reg - CNT_W'(1);
            accepted_next = 1'b1;
            front_next    = (count_reg > CNT_W'(1)) ? second_val : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_xfer) begin
            accepted_reg <= accepted_next;
            front_reg    <= front_next;
            occ_reg      <= OW'(count_next);
            empty_reg    <= (count_next == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = accepted_reg;
    assign m_front_value = front_reg;
    assign m_occupancy   = occ_reg;
    assign m_is_empty    = empty_reg;

endmodule

### design/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks for the min-heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker #(
    parameter int CAPACITY = 16
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_accepted,
    input logic signed [mhpq_pkg::DATA_W-1:0] m_front_value,
    input logic [mhpq_pkg::OCC_W-1:0]         m_occupancy,
    input logic                               m_is_empty
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_front_value) &&
        $stable(m_occupancy) && $stable(m_accepted) && $stable(m_is_empty))
        else $error("result changed while stalled");

    // input only stalls behind a waiting result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // empty queue reports zero minimum
    a_empty_front: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_front_value == '0 && m_occupancy == '0)
        else $error("empty queue with nonzero front or count");

    // a nonzero count is never reported as empty
    a_count_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_occupancy != '0 |-> !m_is_empty)
        else $error("empty flag with entries stored");

    // count stays within capacity
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CAPACITY > 31) || (32'(m_occupancy) <= CAPACITY))
        else $error("count above capacity");

endmodule

bind min_heap_priority_queue mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);
